// ===== src/mrt_pkg.sv =====
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared constants and types of the mesh route table: status and operation
// codes, register indexes, reset values, scan carry and write command.
// ----------------------------------------------------------------------------
`default_nettype none

package mrt_pkg;

	localparam int ROUTES_DEF  = 16;
	localparam int ID_BITS_DEF = 32;

	localparam int FIELD_ID_W = 32;
	localparam int TIME_W     = 32;
	localparam int HOPS_W     = 8;
	localparam int RSSI_W     = 8;
	localparam int MARGIN_W   = 7;
	localparam int STATUS_W   = 3;
	localparam int SLOT_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EXPIRED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REFUSED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd4;
	localparam logic [STATUS_W-1:0] ST_KEPT     = 3'd5;
	localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd6;
	localparam logic [STATUS_W-1:0] ST_EVICTED  = 3'd7;

	localparam logic [CFG_IDX_W-1:0] REG_HOP_LIMIT    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROUTE_TMO    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_MARGIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_MARGIN = 2'd3;

	localparam logic [HOPS_W-1:0]   HOP_LIMIT_RST = 8'd7;
	localparam logic [TIME_W-1:0]   ROUTE_TMO_RST = 32'd60000;
	localparam logic [MARGIN_W-1:0] MARGIN_RST    = 7'd5;

	typedef struct packed {
		logic                     tok;
		logic                     hit;
		logic                     free;
		logic [TIME_W-1:0]        hit_stamp;
		logic [HOPS_W-1:0]        hit_hops;
		logic signed [RSSI_W-1:0] hit_rssi;
		logic [TIME_W-1:0]        old_age;
	} scan_t;

	typedef struct packed {
		logic wr;
		logic clr;
	} cmd_t;

endpackage

`default_nettype wire

// ===== src/mesh_route_table_top.sv =====
// ----------------------------------------------------------------------------
// mesh_route_table_top
// Route cache of a mesh radio node: a row of route cells scanned by a token
// that gathers match, first free slot and oldest entry, then one update.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with operation, dev_id, relay_id, hop_count, rssi and
//   now_time while busy is low; the item is taken at that clock edge.
//   The scan token walks the cell row one cell a cycle, and the result
//   (status, next_hop, slot) appears with done high for one cycle once the
//   token has passed the last cell; busy falls together with done.
//   A new item can be taken in the cycle done is shown; no new item is
//   taken while busy is high, so one item is handled at a time.
//   done is not held: the result must be taken in its one cycle.
//   Registers are written through cfg_we, cfg_index, cfg_data while idle.
//   Reset clears all route entries to inactive and loads the register
//   defaults (hop limit 7, timeout 60000, both margins 5).
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_route_table_top #(
	parameter int ROUTES  = mrt_pkg::ROUTES_DEF,
	parameter int ID_BITS = mrt_pkg::ID_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire                                  operation,
	input  wire [mrt_pkg::FIELD_ID_W-1:0]        dev_id,
	input  wire [mrt_pkg::FIELD_ID_W-1:0]        relay_id,
	input  wire [mrt_pkg::HOPS_W-1:0]            hop_count,
	input  wire signed [mrt_pkg::RSSI_W-1:0]     rssi,
	input  wire [mrt_pkg::TIME_W-1:0]            now_time,
	output logic                                 done,
	output logic [mrt_pkg::STATUS_W-1:0]         status,
	output logic [mrt_pkg::FIELD_ID_W-1:0]       next_hop,
	output logic [mrt_pkg::SLOT_W-1:0]           slot,
	input  wire                                  cfg_we,
	input  wire [mrt_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire [mrt_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import mrt_pkg::*;

	localparam int IDX_W  = (ROUTES > 1) ? $clog2(ROUTES) : 1;
	localparam int WIDE_W = ID_BITS + FIELD_ID_W;
	localparam int RC_W   = RSSI_W + 2;

	logic [HOPS_W-1:0]   hop_limit_q;
	logic [TIME_W-1:0]   route_tmo_q;
	logic [MARGIN_W-1:0] upper_q;
	logic [MARGIN_W-1:0] lower_q;

	logic                     busy_q;
	logic                     tok_q;
	logic                     op_q;
	logic [ID_BITS-1:0]       id_q;
	logic [ID_BITS-1:0]       relay_q;
	logic [HOPS_W-1:0]        hops_q;
	logic signed [RSSI_W-1:0] rssi_q;
	logic [TIME_W-1:0]        now_q;

	logic                  done_q;
	logic [STATUS_W-1:0]   status_q;
	logic [FIELD_ID_W-1:0] next_hop_q;
	logic [SLOT_W-1:0]     slot_q;

	logic                  accept;
	logic [WIDE_W-1:0]     dev_wide;
	logic [WIDE_W-1:0]     relay_wide;

	scan_t              carry    [ROUTES+1];
	logic [IDX_W-1:0]   hit_idx  [ROUTES+1];
	logic [IDX_W-1:0]   free_idx [ROUTES+1];
	logic [IDX_W-1:0]   old_idx  [ROUTES+1];
	logic [ID_BITS-1:0] hit_hop  [ROUTES+1];
	logic [ROUTES-1:0]  tok_vec;

	scan_t               fin;
	cmd_t                cmd;
	logic [IDX_W-1:0]    cmd_idx;
	logic [STATUS_W-1:0] st_d;
	logic [IDX_W-1:0]    res_idx;
	logic [SLOT_W-1:0]   res_slot;
	logic [WIDE_W-1:0]   hop_wide;
	logic [TIME_W-1:0]   hit_age;
	logic                fresh;
	logic                refuse;
	logic signed [RC_W-1:0] new_rc;
	logic signed [RC_W-1:0] old_rc;
	logic signed [RC_W-1:0] up_rc;
	logic signed [RC_W-1:0] dn_rc;
	logic                better;
	logic [IDX_W+SLOT_W-1:0] slot_wide;

	assign accept     = start && !busy_q;
	assign dev_wide   = {{ID_BITS{1'b0}}, dev_id};
	assign relay_wide = {{ID_BITS{1'b0}}, relay_id};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_limit_q <= HOP_LIMIT_RST;
			route_tmo_q <= ROUTE_TMO_RST;
			upper_q     <= MARGIN_RST;
			lower_q     <= MARGIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HOP_LIMIT:    hop_limit_q <= cfg_data[HOPS_W-1:0];
				REG_ROUTE_TMO:    route_tmo_q <= cfg_data[TIME_W-1:0];
				REG_UPPER_MARGIN: upper_q     <= cfg_data[MARGIN_W-1:0];
				REG_LOWER_MARGIN: lower_q     <= cfg_data[MARGIN_W-1:0];
				default:          hop_limit_q <= hop_limit_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			id_q    <= dev_wide[ID_BITS-1:0];
			relay_q <= relay_wide[ID_BITS-1:0];
			hops_q  <= hop_count;
			rssi_q  <= rssi;
			now_q   <= now_time;
		end
	end

	always_comb begin
		carry[0]           = '0;
		carry[0].tok       = tok_q;
		hit_idx[0]         = '0;
		free_idx[0]        = '0;
		old_idx[0]         = '0;
		hit_hop[0]         = '0;
	end

	for (genvar g = 0; g < ROUTES; g++) begin : g_cell
		mrt_cell #(
			.IDX     (g),
			.ROUTES  (ROUTES),
			.ID_BITS (ID_BITS),
			.IDX_W   (IDX_W)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.qry_id       (id_q),
			.qry_relay    (relay_q),
			.qry_hops     (hops_q),
			.qry_rssi     (rssi_q),
			.qry_now      (now_q),
			.cmd          (cmd),
			.cmd_idx      (cmd_idx),
			.carry_in     (carry[g]),
			.hit_idx_in   (hit_idx[g]),
			.free_idx_in  (free_idx[g]),
			.old_idx_in   (old_idx[g]),
			.hit_hop_in   (hit_hop[g]),
			.carry_out    (carry[g+1]),
			.hit_idx_out  (hit_idx[g+1]),
			.free_idx_out (free_idx[g+1]),
			.old_idx_out  (old_idx[g+1]),
			.hit_hop_out  (hit_hop[g+1])
		);
		assign tok_vec[g] = carry[g+1].tok;
	end

	assign fin     = carry[ROUTES];
	assign hit_age = now_q - fin.hit_stamp;
	assign fresh   = hit_age < route_tmo_q;
	assign refuse  = ({1'b0, hops_q} + 9'd1) >= {1'b0, hop_limit_q};
	assign new_rc  = RC_W'(rssi_q);
	assign old_rc  = RC_W'(fin.hit_rssi);
	assign up_rc   = old_rc + $signed({3'b000, upper_q});
	assign dn_rc   = old_rc - $signed({3'b000, lower_q});

	always_comb begin
		if (new_rc > up_rc) begin
			better = 1'b1;
		end else if (new_rc < dn_rc) begin
			better = 1'b0;
		end else begin
			better = hops_q < fin.hit_hops;
		end
	end

	always_comb begin
		cmd     = '0;
		cmd_idx = hit_idx[ROUTES];
		st_d    = ST_MISS;
		res_idx = '0;
		if (op_q == OP_LOOKUP) begin
			if (!fin.hit) begin
				st_d = ST_MISS;
			end else if (fresh) begin
				st_d    = ST_HIT;
				res_idx = hit_idx[ROUTES];
			end else begin
				st_d    = ST_EXPIRED;
				res_idx = hit_idx[ROUTES];
				cmd.clr = fin.tok;
			end
		end else if (refuse) begin
			st_d = ST_REFUSED;
		end else if (fin.hit) begin
			res_idx = hit_idx[ROUTES];
			if (better) begin
				st_d   = ST_REPLACED;
				cmd.wr = fin.tok;
			end else begin
				st_d = ST_KEPT;
			end
		end else if (fin.free) begin
			st_d    = ST_ADDED;
			res_idx = free_idx[ROUTES];
			cmd_idx = free_idx[ROUTES];
			cmd.wr  = fin.tok;
		end else begin
			st_d    = ST_EVICTED;
			res_idx = old_idx[ROUTES];
			cmd_idx = old_idx[ROUTES];
			cmd.wr  = fin.tok;
		end
	end

	assign slot_wide = {{SLOT_W{1'b0}}, res_idx};
	assign res_slot  = slot_wide[SLOT_W-1:0];
	assign hop_wide  = {{FIELD_ID_W{1'b0}}, hit_hop[ROUTES]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			tok_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			tok_q  <= accept;
			done_q <= fin.tok;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin.tok) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin.tok) begin
			status_q   <= st_d;
			slot_q     <= res_slot;
			next_hop_q <= (st_d == ST_HIT) ? hop_wide[FIELD_ID_W-1:0] : '0;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign status   = status_q;
	assign next_hop = next_hop_q;
	assign slot     = slot_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({tok_vec, tok_q}))
		else $error("more than one scan token in the cell row");

	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		fin.tok |-> busy_q)
		else $error("scan finished while idle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && tok_q)
		else $error("accepted item did not start a scan");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && !tok_q)
		else $error("result shown while a scan is running");

	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr && cmd.clr) && (!(cmd.wr || cmd.clr) || fin.tok))
		else $error("bad write command to the cell row");

endmodule

`default_nettype wire

// ===== src/mrt_cell.sv =====
// ----------------------------------------------------------------------------
// mrt_cell
// One route entry of the table. Folds its entry into the scan carry that
// passes through it and takes writes and deactivations from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module mrt_cell #(
	parameter int IDX     = 0,
	parameter int ROUTES  = mrt_pkg::ROUTES_DEF,
	parameter int ID_BITS = mrt_pkg::ID_BITS_DEF,
	parameter int IDX_W   = (ROUTES > 1) ? $clog2(ROUTES) : 1
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire [ID_BITS-1:0]                      qry_id,
	input  wire [ID_BITS-1:0]                      qry_relay,
	input  wire [mrt_pkg::HOPS_W-1:0]              qry_hops,
	input  wire signed [mrt_pkg::RSSI_W-1:0]       qry_rssi,
	input  wire [mrt_pkg::TIME_W-1:0]              qry_now,
	input  wire mrt_pkg::cmd_t                     cmd,
	input  wire [IDX_W-1:0]                        cmd_idx,
	input  wire mrt_pkg::scan_t                    carry_in,
	input  wire [IDX_W-1:0]                        hit_idx_in,
	input  wire [IDX_W-1:0]                        free_idx_in,
	input  wire [IDX_W-1:0]                        old_idx_in,
	input  wire [ID_BITS-1:0]                      hit_hop_in,
	output mrt_pkg::scan_t                         carry_out,
	output logic [IDX_W-1:0]                       hit_idx_out,
	output logic [IDX_W-1:0]                       free_idx_out,
	output logic [IDX_W-1:0]                       old_idx_out,
	output logic [ID_BITS-1:0]                     hit_hop_out
);
	import mrt_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic                     valid_q;
	logic [ID_BITS-1:0]       dest_q;
	logic [ID_BITS-1:0]       hop_q;
	logic [HOPS_W-1:0]        hops_q;
	logic signed [RSSI_W-1:0] rssi_q;
	logic [TIME_W-1:0]        stamp_q;

	scan_t              carry_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic [IDX_W-1:0]   old_idx_q;
	logic [ID_BITS-1:0] hit_hop_q;

	logic              sel;
	logic              match;
	logic [TIME_W-1:0] age;
	logic              take_hit;
	logic              take_free;
	logic              take_old;
	scan_t             carry_d;

	assign sel       = (cmd_idx == MY_IDX);
	assign match     = valid_q && (dest_q == qry_id);
	assign age       = qry_now - stamp_q;
	assign take_hit  = carry_in.tok && match && !carry_in.hit;
	assign take_free = carry_in.tok && !valid_q && !carry_in.free;
	assign take_old  = carry_in.tok && (age > carry_in.old_age);

	always_comb begin
		carry_d = carry_in;
		if (take_hit) begin
			carry_d.hit       = 1'b1;
			carry_d.hit_stamp = stamp_q;
			carry_d.hit_hops  = hops_q;
			carry_d.hit_rssi  = rssi_q;
		end
		if (take_free) begin
			carry_d.free = 1'b1;
		end
		if (take_old) begin
			carry_d.old_age = age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			carry_q <= '0;
		end else begin
			carry_q <= carry_d;
			if (sel && cmd.wr) begin
				valid_q <= 1'b1;
			end else if (sel && cmd.clr) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel && cmd.wr) begin
			dest_q  <= qry_id;
			hop_q   <= qry_relay;
			hops_q  <= qry_hops;
			rssi_q  <= qry_rssi;
			stamp_q <= qry_now;
		end
		hit_idx_q  <= take_hit ? MY_IDX : hit_idx_in;
		hit_hop_q  <= take_hit ? hop_q : hit_hop_in;
		free_idx_q <= take_free ? MY_IDX : free_idx_in;
		old_idx_q  <= take_old ? MY_IDX : old_idx_in;
	end

	assign carry_out    = carry_q;
	assign hit_idx_out  = hit_idx_q;
	assign free_idx_out = free_idx_q;
	assign old_idx_out  = old_idx_q;
	assign hit_hop_out  = hit_hop_q;

endmodule

`default_nettype wire

// ===== sim/mesh_route_table_chk.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mesh_route_table_chk
// Watches the item, result and register ports of the route table, keeps its
// own copy of the route entries and registers, predicts the result of every
// accepted item and compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module mesh_route_table_chk
	import mrt_pkg::*;
#(
	parameter int ROUTES = ROUTES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire                          busy,
	input  wire                          operation,
	input  wire [FIELD_ID_W-1:0]         dev_id,
	input  wire [FIELD_ID_W-1:0]         relay_id,
	input  wire [HOPS_W-1:0]             hop_count,
	input  wire signed [RSSI_W-1:0]      rssi,
	input  wire [TIME_W-1:0]             now_time,
	input  wire                          done,
	input  wire [STATUS_W-1:0]           status,
	input  wire [FIELD_ID_W-1:0]         next_hop,
	input  wire [SLOT_W-1:0]             slot,
	input  wire                          cfg_we,
	input  wire [CFG_IDX_W-1:0]          cfg_index,
	input  wire [CFG_DATA_W-1:0]         cfg_data,
	output int                           pending,
	output int                           errors
);

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [FIELD_ID_W-1:0] next_hop;
		logic [SLOT_W-1:0]     slot;
	} route_res_t;

	logic                     tbl_valid [ROUTES];
	logic [FIELD_ID_W-1:0]    tbl_dest  [ROUTES];
	logic [FIELD_ID_W-1:0]    tbl_relay [ROUTES];
	logic [HOPS_W-1:0]        tbl_hops  [ROUTES];
	logic signed [RSSI_W-1:0] tbl_rssi  [ROUTES];
	logic [TIME_W-1:0]        tbl_stamp [ROUTES];

	logic [HOPS_W-1:0]   lim_hops;
	logic [TIME_W-1:0]   lim_age;
	logic [MARGIN_W-1:0] gain_margin;
	logic [MARGIN_W-1:0] loss_margin;

	route_res_t route_q [$];

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (errors < 50)
			$display("%0t route check: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic void store_route(int idx, logic [FIELD_ID_W-1:0] id,
			logic [FIELD_ID_W-1:0] relay, logic [HOPS_W-1:0] hops,
			logic signed [RSSI_W-1:0] sig, logic [TIME_W-1:0] now);
		tbl_valid[idx] = 1'b1;
		tbl_dest[idx]  = id;
		tbl_relay[idx] = relay;
		tbl_hops[idx]  = hops;
		tbl_rssi[idx]  = sig;
		tbl_stamp[idx] = now;
	endfunction

	function automatic route_res_t route_outcome(logic op, logic [FIELD_ID_W-1:0] id,
			logic [FIELD_ID_W-1:0] relay, logic [HOPS_W-1:0] hops,
			logic signed [RSSI_W-1:0] sig, logic [TIME_W-1:0] now);
		route_res_t r;
		int i;
		int hit_idx;
		int free_idx;
		int old_idx;
		logic [TIME_W-1:0] age;
		logic [TIME_W-1:0] old_age;
		logic better;
		r.status   = ST_MISS;
		r.next_hop = '0;
		r.slot     = '0;
		hit_idx  = -1;
		free_idx = -1;
		old_idx  = 0;
		old_age  = now - tbl_stamp[0];
		for (i = 0; i < ROUTES; i++) begin
			if (tbl_valid[i] && tbl_dest[i] == id && hit_idx < 0)
				hit_idx = i;
			if (!tbl_valid[i] && free_idx < 0)
				free_idx = i;
			age = now - tbl_stamp[i];
			if (age > old_age) begin
				old_age = age;
				old_idx = i;
			end
		end
		if (op == OP_LOOKUP) begin
			if (hit_idx >= 0) begin
				r.slot = SLOT_W'(hit_idx);
				if (TIME_W'(now - tbl_stamp[hit_idx]) < lim_age) begin
					r.status   = ST_HIT;
					r.next_hop = tbl_relay[hit_idx];
				end else begin
					r.status = ST_EXPIRED;
					tbl_valid[hit_idx] = 1'b0;
				end
			end
			return r;
		end
		if (int'(hops) >= int'(lim_hops) - 1) begin
			r.status = ST_REFUSED;
			return r;
		end
		if (hit_idx >= 0) begin
			if (int'(sig) > int'(tbl_rssi[hit_idx]) + int'(gain_margin))
				better = 1'b1;
			else if (int'(sig) < int'(tbl_rssi[hit_idx]) - int'(loss_margin))
				better = 1'b0;
			else
				better = hops < tbl_hops[hit_idx];
			r.slot = SLOT_W'(hit_idx);
			if (better) begin
				store_route(hit_idx, id, relay, hops, sig, now);
				r.status = ST_REPLACED;
			end else begin
				r.status = ST_KEPT;
			end
		end else if (free_idx >= 0) begin
			store_route(free_idx, id, relay, hops, sig, now);
			r.status = ST_ADDED;
			r.slot   = SLOT_W'(free_idx);
		end else begin
			store_route(old_idx, id, relay, hops, sig, now);
			r.status = ST_EVICTED;
			r.slot   = SLOT_W'(old_idx);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		route_res_t want;
		if (!arst_n) begin
			for (int i = 0; i < ROUTES; i++) begin
				tbl_valid[i] = 1'b0;
				tbl_dest[i]  = '0;
				tbl_relay[i] = '0;
				tbl_hops[i]  = '0;
				tbl_rssi[i]  = '0;
				tbl_stamp[i] = '0;
			end
			lim_hops    = HOP_LIMIT_RST;
			lim_age     = ROUTE_TMO_RST;
			gain_margin = MARGIN_RST;
			loss_margin = MARGIN_RST;
			route_q.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (route_q.size() == 0) begin
					report_mismatch("unexpected item, status", status, '0);
				end else begin
					want = route_q.pop_front();
					if (status !== want.status)
						report_mismatch("status", status, want.status);
					if (next_hop !== want.next_hop)
						report_mismatch("next_hop", next_hop, want.next_hop);
					if (slot !== want.slot)
						report_mismatch("slot", slot, want.slot);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_HOP_LIMIT:    lim_hops    = cfg_data[HOPS_W-1:0];
					REG_ROUTE_TMO:    lim_age     = cfg_data[TIME_W-1:0];
					REG_UPPER_MARGIN: gain_margin = cfg_data[MARGIN_W-1:0];
					REG_LOWER_MARGIN: loss_margin = cfg_data[MARGIN_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy)
				route_q.push_back(route_outcome(operation, dev_id, relay_id, hop_count,
					rssi, now_time));
			pending <= route_q.size();
		end
	end

endmodule

// ===== sim/mesh_route_table_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mesh_route_table_top_tb
// Drives the route table with directed updates and lookups, then with bursts
// of random route traffic over a small id pool under several register
// settings; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module mesh_route_table_top_tb;
	import mrt_pkg::*;

	localparam int ROUTES = ROUTES_DEF;
	localparam int POOL   = 20;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     operation;
	logic [FIELD_ID_W-1:0]    dev_id;
	logic [FIELD_ID_W-1:0]    relay_id;
	logic [HOPS_W-1:0]        hop_count;
	logic signed [RSSI_W-1:0] rssi;
	logic [TIME_W-1:0]        now_time;
	logic                     done;
	logic [STATUS_W-1:0]      status;
	logic [FIELD_ID_W-1:0]    next_hop;
	logic [SLOT_W-1:0]        slot;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_DATA_W-1:0]    cfg_data;
	int                       pending;
	int                       errors;

	logic [FIELD_ID_W-1:0] id_pool [POOL];
	logic [TIME_W-1:0]     now_cnt;
	logic [HOPS_W-1:0]     cur_hop_limit;
	int                    time_step;

	mesh_route_table_top #(.ROUTES(ROUTES)) DUT (.*);

	mesh_route_table_chk #(.ROUTES(ROUTES)) u_chk (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	task automatic issue(logic op, logic [FIELD_ID_W-1:0] id, logic [FIELD_ID_W-1:0] relay,
			logic [HOPS_W-1:0] hops, logic signed [RSSI_W-1:0] sig, logic [TIME_W-1:0] t);
		start     <= 1'b1;
		operation <= op;
		dev_id    <= id;
		relay_id  <= relay;
		hop_count <= hops;
		rssi      <= sig;
		now_time  <= t;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic send_random_item();
		logic                     op;
		logic [FIELD_ID_W-1:0]    id;
		logic [HOPS_W-1:0]        hops;
		logic signed [RSSI_W-1:0] sig;
		int                       roll;
		op = ($urandom_range(0, 99) < 45) ? OP_LOOKUP : OP_UPDATE;
		id = ($urandom_range(0, 9) == 0) ? FIELD_ID_W'($urandom)
			: id_pool[$urandom_range(0, POOL - 1)];
		if (cur_hop_limit >= 2 && $urandom_range(0, 6) != 0)
			hops = HOPS_W'($urandom_range(0, int'(cur_hop_limit) - 2));
		else
			hops = HOPS_W'($urandom_range(0, 255));
		// cluster half of the strengths so the hysteresis band is hit often
		if ($urandom_range(0, 1) == 0)
			sig = RSSI_W'($urandom_range(196, 216));
		else
			sig = RSSI_W'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 4)
			now_cnt = $urandom;
		else if (roll < 8)
			now_cnt = now_cnt - TIME_W'($urandom_range(0, time_step));
		else
			now_cnt = now_cnt + TIME_W'($urandom_range(0, time_step));
		issue(op, id, $urandom, hops, sig, now_cnt);
	endtask

	task automatic run_phase(logic [HOPS_W-1:0] hl, logic [TIME_W-1:0] tmo,
			logic [MARGIN_W-1:0] up, logic [MARGIN_W-1:0] lo, int count);
		int sent;
		int burst;
		int gap;
		drain();
		write_reg(REG_HOP_LIMIT, CFG_DATA_W'(hl));
		write_reg(REG_ROUTE_TMO, CFG_DATA_W'(tmo));
		write_reg(REG_UPPER_MARGIN, CFG_DATA_W'(up));
		write_reg(REG_LOWER_MARGIN, CFG_DATA_W'(lo));
		cfg_we <= 1'b0;
		cur_hop_limit = hl;
		time_step = ((tmo >> 3) > 32'h0010_0000) ? 32'h0010_0000 : int'(tmo >> 3) + 1;
		sent = 0;
		while (sent < count) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && sent < count) begin
				send_random_item();
				sent++;
				burst--;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		operation = OP_UPDATE;
		dev_id    = '0;
		relay_id  = '0;
		hop_count = '0;
		rssi      = '0;
		now_time  = '0;
		cfg_we    = 1'b0;
		cfg_index = REG_HOP_LIMIT;
		cfg_data  = '0;
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int i = 2; i < POOL; i++)
			id_pool[i] = $urandom;
		cur_hop_limit = HOP_LIMIT_RST;
		time_step     = 1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 8'd0, 8'sd0, 32'd0);
		issue(OP_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, -8'sd128, 32'd0);
		issue(OP_UPDATE, 32'h1234_5678, 32'h0000_0001, 8'd6, 8'sd0, 32'd10);
		issue(OP_UPDATE, 32'h1234_5678, 32'h0000_0001, 8'd255, 8'sd127, 32'd20);
		issue(OP_UPDATE, 32'h0000_0000, 32'h0000_0000, 8'd5, 8'sd127, 32'd100);
		issue(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 8'd0, 8'sd0, 32'd59999);
		issue(OP_UPDATE, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 8'd5, -8'sd122, 32'd200);
		issue(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_0001, 8'd0, -8'sd128, 32'd300);
		issue(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_0002, 8'd4, -8'sd127, 32'd400);
		issue(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_0003, 8'd4, -8'sd117, 32'd500);
		issue(OP_UPDATE, 32'hFFFF_FFFF, 32'h0000_0004, 8'd4, -8'sd112, 32'd600);
		issue(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 8'd0, 8'sd0, 32'd60100);
		issue(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 8'd0, 8'sd0, 32'd60200);
		issue(OP_UPDATE, 32'h5A5A_5A5A, 32'h3C3C_3C3C, 8'd1, 8'sd0, 32'hFFFF_FFF0);
		issue(OP_LOOKUP, 32'h5A5A_5A5A, 32'h0000_0000, 8'd0, 8'sd0, 32'h0000_0010);
		issue(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 8'd0, 8'sd0, 32'h0000_0010);
		now_cnt = 32'h0000_0010;

		run_phase(8'd16,  32'd5000,       7'd5,   7'd5,   160);
		run_phase(8'd255, 32'hFFFF_FFFF,  7'd127, 7'd127, 160);
		run_phase(8'd0,   32'd0,          7'd0,   7'd0,   40);
		run_phase(8'd2,   32'd1,          7'd0,   7'd127, 80);
		run_phase(8'd200, 32'd300,        7'd127, 7'd0,   160);
		run_phase(8'd10,  32'd20000,      7'd3,   7'd8,   200);
		run_phase(8'd64,  32'd100000,     7'd0,   7'd0,   200);
		run_phase(HOP_LIMIT_RST, ROUTE_TMO_RST, MARGIN_RST, MARGIN_RST, 100);

		drain();
		repeat (ROUTES + 8) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
